// ===== sv/pms_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic message scheduler package
// Shared types, command codes and constants of the scheduler.
// ----------------------------------------------------------------------------
package pms_pkg;

  localparam int FUNC_W    = 3;
  localparam int CHAN_W    = 4;
  localparam int KIND_W    = 2;
  localparam int SLOT_IX_W = 2;
  localparam int ID_W      = 11;
  localparam int LEN_W     = 7;
  localparam int CYCLE_W   = 16;
  localparam int CNT_W     = 32;
  localparam int STEP_W    = 8;
  localparam int OFFSET_W  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int ENTRY_W   = 35;
  localparam int OP_W      = 3;

  localparam int ENTRY_REGS = 4;
  localparam int QDEPTH     = 2;

  localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_START   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ENABLE  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DISABLE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_INIT    = 3'd4;

  localparam logic [KIND_W-1:0] KIND_TX        = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STATUS    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SLEEP_ACK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_STEP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_CHANNEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT0        = 3'd3;

  localparam logic [STEP_W-1:0]   TICK_STEP_RST    = 8'd10;
  localparam logic [OFFSET_W-1:0] START_OFFSET_RST = 8'd5;
  localparam logic [CHAN_W-1:0]   OWN_CHANNEL_RST  = 4'd0;

  localparam int RELOAD_EXTRA    = 10;
  localparam int ENABLE_BACKOFF  = 7;
  localparam int DISABLE_BACKOFF = 3;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_TICK    = 3'd0;
  localparam op_t OP_SLEEP   = 3'd1;
  localparam op_t OP_START   = 3'd2;
  localparam op_t OP_ENABLE  = 3'd3;
  localparam op_t OP_DISABLE = 3'd4;
  localparam op_t OP_INIT    = 3'd5;
  localparam op_t OP_REJECT  = 3'd6;

  typedef struct packed {
    logic [LEN_W-1:0]   length;
    logic               fd;
    logic [ID_W-1:0]    id;
    logic [CYCLE_W-1:0] cycle;
  } entry_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic [STEP_W-1:0]   tick_step;
    logic [OFFSET_W-1:0] start_offset;
  } sched_cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [SLOT_IX_W-1:0] slot_index;
    logic [ID_W-1:0]      message_id;
    logic [LEN_W-1:0]     message_length;
    logic                 fd_frame;
    logic                 status;
    logic                 last;
  } result_t;

endpackage

// ===== sv/pms_if.sv =====
// ----------------------------------------------------------------------------
// Periodic message scheduler channels
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface pms_item_if;
  import pms_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CHAN_W-1:0] channel;
  logic              awake;
  modport source (output valid, func, channel, awake, input ready);
  modport sink   (input valid, func, channel, awake, output ready);
endinterface

interface pms_result_if;
  import pms_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [SLOT_IX_W-1:0] slot_index;
  logic [ID_W-1:0]      message_id;
  logic [LEN_W-1:0]     message_length;
  logic                 fd_frame;
  logic                 status;
  logic                 last;
  modport source (output valid, kind, slot_index, message_id, message_length, fd_frame,
                  status, last, input ready);
  modport sink   (input valid, kind, slot_index, message_id, message_length, fd_frame,
                  status, last, output ready);
endinterface

interface pms_cfg_if;
  import pms_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ENTRY_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/periodic_message_scheduler_unit.sv =====
// Start, reject and sleep items give a registered result when taken from the queue; tick,
// enable, disable and init visit one slot counter per cycle while the output is free.
// The slot sequencer, with its single counter adder, ends a slot-scanning item before it
// takes the next command; other items go one per cycle while the output can accept.
// Reset (rst_n low, synchronous): registers to defaults, counters and flags cleared.
// ----------------------------------------------------------------------------
// Periodic message scheduler
// Front end, command queue and slot sequencer of the periodic scheduler.
// ----------------------------------------------------------------------------
module periodic_message_scheduler_unit #(
  parameter int SLOTS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  pms_item_if.sink     in_ch,
  pms_result_if.source out_ch,
  pms_cfg_if.sink      cfg_ch
);
  import pms_pkg::*;

  logic       push_vld, push_rdy;
  cmd_t       push_cmd;
  logic       pop_vld, pop_rdy;
  cmd_t       pop_cmd;
  sched_cfg_t sched_cfg;
  entry_t     ent [SLOTS];

  pms_front #(.SLOTS(SLOTS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .push_vld  (push_vld),
    .push_rdy  (push_rdy),
    .push_cmd  (push_cmd),
    .sched_cfg (sched_cfg),
    .ent       (ent)
  );

  pms_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_vld (push_vld),
    .push_rdy (push_rdy),
    .push_cmd (push_cmd),
    .pop_vld  (pop_vld),
    .pop_rdy  (pop_rdy),
    .pop_cmd  (pop_cmd)
  );

  pms_back #(.SLOTS(SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_vld   (pop_vld),
    .pop_rdy   (pop_rdy),
    .pop_cmd   (pop_cmd),
    .sched_cfg (sched_cfg),
    .ent       (ent),
    .out_ch    (out_ch)
  );

  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == KIND_STATUS |-> out_ch.last)
    else $error("status result not marked last");

  a_fail_only_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind != KIND_STATUS |-> !out_ch.status)
    else $error("failure flag outside a status result");

  a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    pop_vld && pop_rdy |-> !out_ch.valid || out_ch.ready)
    else $error("command taken with the output register blocked");

  a_unknown_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.func > FUNC_INIT |-> !push_vld)
    else $error("unknown function pushed to the queue");

endmodule

// ===== sv/pms_front.sv =====
// ----------------------------------------------------------------------------
// Scheduler front end
// Holds the configuration registers, accepts items and classifies them.
// ----------------------------------------------------------------------------
module pms_front #(
  parameter int SLOTS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  pms_item_if.sink            in_ch,
  pms_cfg_if.sink             cfg_ch,
  output logic                push_vld,
  input  logic                push_rdy,
  output pms_pkg::cmd_t       push_cmd,
  output pms_pkg::sched_cfg_t sched_cfg,
  output pms_pkg::entry_t     ent [SLOTS]
);
  import pms_pkg::*;

  logic [STEP_W-1:0]   tick_step_r;
  logic [OFFSET_W-1:0] start_offset_r;
  logic [CHAN_W-1:0]   own_channel_r;
  logic                known;
  logic                cfg_we;

  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_step_r    <= TICK_STEP_RST;
      start_offset_r <= START_OFFSET_RST;
      own_channel_r  <= OWN_CHANNEL_RST;
    end else if (cfg_we) begin
      case (cfg_ch.index)
        REG_TICK_STEP:    tick_step_r    <= cfg_ch.data[STEP_W-1:0];
        REG_START_OFFSET: start_offset_r <= cfg_ch.data[OFFSET_W-1:0];
        REG_OWN_CHANNEL:  own_channel_r  <= cfg_ch.data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < SLOTS; k++) begin : g_entry
    if (k < ENTRY_REGS) begin : g_reg
      entry_t ent_r;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          ent_r <= '0;
        end else if (cfg_we && cfg_ch.index == CFG_IDX_W'(REG_SLOT0 + k)) begin
          ent_r <= entry_t'(cfg_ch.data);
        end
      end
      assign ent[k] = ent_r;
    end else begin : g_none
      assign ent[k] = '0;
    end
  end

  assign sched_cfg.tick_step    = tick_step_r;
  assign sched_cfg.start_offset = start_offset_r;

  always_comb begin
    known       = in_ch.func inside {[FUNC_TICK:FUNC_INIT]};
    push_cmd.op = OP_START;
    case (in_ch.func)
      FUNC_TICK:    push_cmd.op = in_ch.awake ? OP_TICK : OP_SLEEP;
      FUNC_START:   push_cmd.op = OP_START;
      FUNC_ENABLE:  push_cmd.op = (in_ch.channel == own_channel_r) ? OP_ENABLE : OP_REJECT;
      FUNC_DISABLE: push_cmd.op = (in_ch.channel == own_channel_r) ? OP_DISABLE : OP_REJECT;
      FUNC_INIT:    push_cmd.op = OP_INIT;
      default:      push_cmd.op = OP_START;
    endcase
  end

  // drop unknown functions at the door
  assign in_ch.ready = push_rdy;
  assign push_vld    = in_ch.valid && known;

endmodule

// ===== sv/pms_queue.sv =====
// ----------------------------------------------------------------------------
// Scheduler command queue
// Two-entry queue between the front end and the slot sequencer.
// ----------------------------------------------------------------------------
module pms_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_vld,
  output logic          push_rdy,
  input  pms_pkg::cmd_t push_cmd,
  output logic          pop_vld,
  input  logic          pop_rdy,
  output pms_pkg::cmd_t pop_cmd
);
  import pms_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_QW = $clog2(QDEPTH + 1);

  cmd_t              mem_r [QDEPTH];
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [CNT_QW-1:0] fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign push_rdy = fill_r != CNT_QW'(QDEPTH);
  assign pop_vld  = fill_r != '0;
  assign pop_cmd  = mem_r[rptr_r];
  assign do_push  = push_vld && push_rdy;
  assign do_pop   = pop_vld && pop_rdy;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    fill_nxt = fill_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/pms_back.sv =====
// ----------------------------------------------------------------------------
// Scheduler slot sequencer
// Carries out commands, visiting one slot counter per cycle while the output is
// free, and registers the results.
// ----------------------------------------------------------------------------
module pms_back #(
  parameter int SLOTS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_vld,
  output logic                pop_rdy,
  input  pms_pkg::cmd_t       pop_cmd,
  input  pms_pkg::sched_cfg_t sched_cfg,
  input  pms_pkg::entry_t     ent [SLOTS],
  pms_result_if.source        out_ch
);
  import pms_pkg::*;

  localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BSEL_W = 10;
  localparam int SUB_W  = 9;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]       st_r, st_nxt;
  logic [SW-1:0]    slot_r, slot_nxt;
  op_t              op_r, op_nxt;
  logic             reload_r, reload_nxt;
  logic             send_en_r, send_en_nxt;
  logic             asleep_r, asleep_nxt;
  logic [CNT_W-1:0] cnt_r [SLOTS];
  logic [CNT_W-1:0] cnt_nxt;
  logic             cnt_we;
  logic             pend_vld_r, pend_vld_nxt;
  result_t          pend_r, pend_nxt;
  logic             out_vld_r, out_vld_nxt;
  result_t          out_r, out_nxt;

  entry_t           cur;
  logic [CNT_W-1:0] cyc;
  logic             active;
  logic [SUB_W-1:0] start_sub;
  logic [BSEL_W-1:0] bsel;
  logic             use_cyc;
  logic [CNT_W-1:0] add_a;
  logic [CNT_W-1:0] sum;
  logic             due;
  logic             out_free;
  logic             pop;
  result_t          status_ok;

  assign out_free = !out_vld_r || out_ch.ready;
  assign pop_rdy  = (st_r == ST_IDLE) && out_free;
  assign pop      = pop_vld && pop_rdy;

  always_comb begin
    cur       = ent[slot_r];
    cyc       = CNT_W'(cur.cycle);
    active    = cur.cycle != '0;
    start_sub = SUB_W'(sched_cfg.start_offset) + SUB_W'(RELOAD_EXTRA);
    case (op_r)
      OP_ENABLE:  bsel = BSEL_W'(0) - BSEL_W'(ENABLE_BACKOFF);
      OP_DISABLE: bsel = BSEL_W'(0) - BSEL_W'(DISABLE_BACKOFF);
      OP_INIT:    bsel = BSEL_W'(0) - BSEL_W'(start_sub);
      OP_TICK: begin
        if (reload_r && send_en_r) begin
          bsel = BSEL_W'(sched_cfg.tick_step) - BSEL_W'(start_sub);
        end else if (reload_r) begin
          bsel = BSEL_W'(0) - BSEL_W'(start_sub);
        end else begin
          bsel = BSEL_W'(sched_cfg.tick_step);
        end
      end
      default:    bsel = '0;
    endcase
    use_cyc = (op_r != OP_TICK) || reload_r;
    add_a   = use_cyc ? cyc : cnt_r[slot_r];
    sum     = add_a + {{(CNT_W-BSEL_W){bsel[BSEL_W-1]}}, bsel};
    due     = (op_r == OP_TICK) && send_en_r && active && (sum >= cyc);
    cnt_nxt = due ? '0 : sum;
    case (op_r)
      OP_ENABLE, OP_DISABLE: cnt_we = 1'b1;
      OP_INIT:               cnt_we = active;
      OP_TICK:               cnt_we = active && (reload_r || send_en_r);
      default:               cnt_we = 1'b0;
    endcase
    cnt_we = cnt_we && (st_r == ST_SCAN) && out_free;
  end

  always_comb begin
    status_ok      = '0;
    status_ok.kind = KIND_STATUS;
    status_ok.last = 1'b1;

    st_nxt       = st_r;
    slot_nxt     = slot_r;
    op_nxt       = op_r;
    reload_nxt   = reload_r;
    send_en_nxt  = send_en_r;
    asleep_nxt   = asleep_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_nxt      = out_r;

    case (st_r)
      ST_IDLE: begin
        if (pop) begin
          op_nxt   = pop_cmd.op;
          slot_nxt = '0;
          case (pop_cmd.op)
            OP_SLEEP: begin
              asleep_nxt   = 1'b1;
              out_vld_nxt  = 1'b1;
              out_nxt      = '0;
              out_nxt.kind = KIND_SLEEP_ACK;
              out_nxt.last = 1'b1;
            end
            OP_START: begin
              send_en_nxt = 1'b1;
              out_vld_nxt = 1'b1;
              out_nxt     = status_ok;
            end
            OP_REJECT: begin
              out_vld_nxt    = 1'b1;
              out_nxt        = status_ok;
              out_nxt.status = 1'b1;
            end
            OP_TICK: begin
              reload_nxt = asleep_r;
              asleep_nxt = 1'b0;
              st_nxt     = ST_SCAN;
            end
            OP_ENABLE: begin
              send_en_nxt = 1'b1;
              st_nxt      = ST_SCAN;
            end
            OP_DISABLE, OP_INIT: begin
              send_en_nxt = 1'b0;
              st_nxt      = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          if (due) begin
            if (pend_vld_r) begin
              out_vld_nxt = 1'b1;
              out_nxt     = pend_r;
            end
            pend_vld_nxt            = 1'b1;
            pend_nxt                = '0;
            pend_nxt.kind           = KIND_TX;
            pend_nxt.slot_index     = SLOT_IX_W'(slot_r);
            pend_nxt.message_id     = cur.id;
            pend_nxt.message_length = cur.length;
            pend_nxt.fd_frame       = cur.fd;
          end
          if (slot_r == SW'(SLOTS - 1)) begin
            st_nxt = ST_FINISH;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          if (op_r == OP_TICK) begin
            if (pend_vld_r) begin
              out_vld_nxt  = 1'b1;
              out_nxt      = pend_r;
              out_nxt.last = 1'b1;
            end
          end else begin
            out_vld_nxt = 1'b1;
            out_nxt     = status_ok;
          end
          pend_vld_nxt = 1'b0;
          st_nxt       = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      slot_r     <= '0;
      op_r       <= OP_TICK;
      reload_r   <= 1'b0;
      send_en_r  <= 1'b0;
      asleep_r   <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      slot_r     <= slot_nxt;
      op_r       <= op_nxt;
      reload_r   <= reload_nxt;
      send_en_r  <= send_en_nxt;
      asleep_r   <= asleep_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SLOTS; k++) begin
        cnt_r[k] <= '0;
      end
    end else if (cnt_we) begin
      cnt_r[slot_r] <= cnt_nxt;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.kind           = out_r.kind;
  assign out_ch.slot_index     = out_r.slot_index;
  assign out_ch.message_id     = out_r.message_id;
  assign out_ch.message_length = out_r.message_length;
  assign out_ch.fd_frame       = out_r.fd_frame;
  assign out_ch.status         = out_r.status;
  assign out_ch.last           = out_r.last;

endmodule
